// File: rtl/mvacc_pkg.sv
package mvacc_pkg;

  // field widths
  localparam int IDX_W = 8;
  localparam int VAL_W = 23;

  // tdata layouts
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;
  localparam int IN_IDX_LSB  = 0;
  localparam int IN_MAT_LSB  = 8;
  localparam int IN_VEC_LSB  = 31;
  localparam int OUT_IDX_LSB = 0;
  localparam int OUT_VAL_LSB = 8;

  // reduction datapath
  localparam int PROD_W   = 2 * VAL_W;  // raw product width
  localparam int RED_W    = VAL_W + 1;  // remainder window, holds [0, 2*modulus)
  localparam int MU_SHIFT = PROD_W;     // Barrett scale 2**46

  // sideband that rides along the pipeline
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic             first;
    logic             last;
  } tag_t;

endpackage

// File: rtl/mvacc_ram.sv
module mvacc_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/mvacc_modmul.sv
// (a * b) mod MODULUS, six stages, Barrett with a 2**46 scale.
// q_est = floor(x * mu / 2**46) is q or q-1, so one conditional subtract ends it.
module mvacc_modmul #(
  parameter int MODULUS = 8380417
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  mvacc_pkg::tag_t             tag_i,
  input  logic [mvacc_pkg::VAL_W-1:0] a_i,
  input  logic [mvacc_pkg::VAL_W-1:0] b_i,
  output mvacc_pkg::tag_t             tag_o,
  output logic [mvacc_pkg::VAL_W-1:0] prod_o
);

  localparam int VW = mvacc_pkg::VAL_W;
  localparam int PW = mvacc_pkg::PROD_W;
  localparam int RW = mvacc_pkg::RED_W;

  localparam logic [63:0]   MU_FULL = (64'd1 << mvacc_pkg::MU_SHIFT) / 64'(MODULUS);
  localparam logic [VW-1:0] MU_HI   = MU_FULL[2*VW-1:VW];
  localparam logic [VW-1:0] MU_LO   = MU_FULL[VW-1:0];
  localparam logic [RW-1:0] MOD_R   = RW'(MODULUS);

  mvacc_pkg::tag_t tag1_r, tag2_r, tag3_r, tag4_r, tag5_r, tag6_r;

  logic [PW-1:0]   x1_r;
  logic [PW-1:0]   pp_hh_r, pp_hl_r, pp_lh_r, pp_ll_r;
  logic [RW-1:0]   xl2_r, xl3_r, xl4_r, xl5_r;
  logic [PW:0]     mid3_r;
  logic [PW-1:0]   hh3_r, ll3_r;
  logic [RW-1:0]   q4_r;
  logic [RW-1:0]   qm5_r;
  logic [VW-1:0]   prod6_r;

  logic [PW+RW-1:0] sum4;
  logic [2*RW-1:0]  qm_full;
  logic [RW-1:0]    rem6;
  logic [RW-1:0]    red6;

  // only bits [69:46] of x*mu matter, so hh enters at its low 24 bits
  assign sum4    = {hh3_r[RW-1:0], ll3_r} + {mid3_r, {VW{1'b0}}};
  // remainder lives in [0, 2M) < 2**24: low 24 bits of q*M are enough
  assign qm_full = (2*RW)'(q4_r) * (2*RW)'(MOD_R);
  assign rem6    = xl5_r - qm5_r;
  assign red6    = (rem6 >= MOD_R) ? (rem6 - MOD_R) : rem6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid <= 1'b0;
      tag2_r.valid <= 1'b0;
      tag3_r.valid <= 1'b0;
      tag4_r.valid <= 1'b0;
      tag5_r.valid <= 1'b0;
      tag6_r.valid <= 1'b0;
    end else if (en) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
      tag5_r <= tag4_r;
      tag6_r <= tag5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // s1: raw product
      x1_r    <= PW'(a_i) * PW'(b_i);
      // s2: x * mu as four 23x23 partials
      pp_hh_r <= PW'(x1_r[PW-1:VW]) * PW'(MU_HI);
      pp_hl_r <= PW'(x1_r[PW-1:VW]) * PW'(MU_LO);
      pp_lh_r <= PW'(x1_r[VW-1:0])  * PW'(MU_HI);
      pp_ll_r <= PW'(x1_r[VW-1:0])  * PW'(MU_LO);
      xl2_r   <= x1_r[RW-1:0];
      // s3: fold the cross terms
      mid3_r  <= (PW+1)'(pp_hl_r) + (PW+1)'(pp_lh_r);
      hh3_r   <= pp_hh_r;
      ll3_r   <= pp_ll_r;
      xl3_r   <= xl2_r;
      // s4: quotient estimate, low bits
      q4_r    <= sum4[PW+RW-1:PW];
      xl4_r   <= xl3_r;
      // s5: q * M, low bits
      qm5_r   <= qm_full[RW-1:0];
      xl5_r   <= xl4_r;
      // s6: remainder and correction
      prod6_r <= red6[VW-1:0];
    end
  end

  assign tag_o  = tag6_r;
  assign prod_o = prod6_r;

endmodule

// File: rtl/modq_matrix_vector_accumulate.sv
// Row accumulator for an NTT-domain matrix-vector product mod MODULUS. Each input beat
// carries a coefficient position, a matrix and a vector coefficient, and first/last flags;
// the block forms (mat*vec) mod MODULUS, starts (first) or adds into the accumulator entry
// for that position mod MODULUS, and on the last term emits the finished coefficient.
// Sustained rate is one beat per clock while in_tready is high; each result passes through
// the modular multiply stages, one accumulate stage and the output register.
// The rate is set by the 6-stage Barrett multiplier and by one read-modify-write of the
// accumulator RAM per beat (read one stage ahead, write in the accumulate stage, with a
// one-entry bypass for back-to-back hits on the same position). Input stalls only when a
// finished result sits in the accumulate stage while the output register holds an untaken
// one. Positions at or above N_COEFFS are dropped without effect. Accumulator entries are
// not cleared at reset: a sum must open with a first-term beat for its position.
module modq_matrix_vector_accumulate #(
  parameter int MODULUS  = 8380417,
  parameter int N_COEFFS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mvacc_pkg::IN_TDATA_W-1:0]  in_tdata,   // coef_index, mat_coef, vec_coef, 2'b0
  input  logic                              in_tuser,   // first_term
  input  logic                              in_tlast,   // last_term
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mvacc_pkg::OUT_TDATA_W-1:0] out_tdata   // out_index, out_value, 1'b0
);

  localparam int IW        = mvacc_pkg::IDX_W;
  localparam int VW        = mvacc_pkg::VAL_W;
  localparam int RW        = mvacc_pkg::RED_W;
  localparam int ACC_DEPTH = (N_COEFFS < (1 << IW)) ? N_COEFFS : (1 << IW);
  localparam int AW        = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
  localparam logic [RW-1:0] MOD_R = RW'(MODULUS);

  // pipeline advance: held only when a result must wait for the output register
  logic            adv;
  logic            in_range;
  mvacc_pkg::tag_t tag_in;
  mvacc_pkg::tag_t tag6;
  logic [VW-1:0]   prod6;

  // accumulate stage
  mvacc_pkg::tag_t tag7_r;
  logic [VW-1:0]   prod7_r;
  logic [VW-1:0]   ram_rdata;
  logic [VW-1:0]   acc_old;
  logic [RW-1:0]   acc_sum;
  logic [VW-1:0]   acc_nxt;
  logic            acc_we;

  // bypass of last beat's write (its RAM write raced our read)
  logic            byp_valid_r;
  logic [AW-1:0]   byp_addr_r;
  logic [VW-1:0]   byp_data_r;

  // output register
  logic            out_valid_r;
  logic [IW-1:0]   out_idx_r;
  logic [VW-1:0]   out_val_r;

  assign adv       = !(tag7_r.valid && tag7_r.last && out_valid_r && !out_tready);
  assign in_tready = adv;

  assign in_range     = 32'(in_tdata[mvacc_pkg::IN_IDX_LSB +: IW]) < N_COEFFS;
  assign tag_in.valid = in_tvalid && in_range;
  assign tag_in.index = in_tdata[mvacc_pkg::IN_IDX_LSB +: IW];
  assign tag_in.first = in_tuser;
  assign tag_in.last  = in_tlast;

  mvacc_modmul #(
    .MODULUS (MODULUS)
  ) u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .tag_i  (tag_in),
    .a_i    (in_tdata[mvacc_pkg::IN_MAT_LSB +: VW]),
    .b_i    (in_tdata[mvacc_pkg::IN_VEC_LSB +: VW]),
    .tag_o  (tag6),
    .prod_o (prod6)
  );

  // read issued while the beat is in stage 6, data lands with it in stage 7
  mvacc_ram #(
    .WIDTH (VW),
    .DEPTH (ACC_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (tag7_r.index[AW-1:0]),
    .wdata (acc_nxt),
    .re    (adv),
    .raddr (tag6.index[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign acc_old = (byp_valid_r && (byp_addr_r == tag7_r.index[AW-1:0])) ? byp_data_r
                                                                           : ram_rdata;
  assign acc_sum = RW'(acc_old) + RW'(prod7_r);
  always_comb begin
    if (tag7_r.first) begin
      acc_nxt = prod7_r;
    end else if (acc_sum >= MOD_R) begin
      acc_nxt = VW'(acc_sum - MOD_R);
    end else begin
      acc_nxt = acc_sum[VW-1:0];
    end
  end
  assign acc_we = adv && tag7_r.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag7_r.valid <= 1'b0;
      byp_valid_r  <= 1'b0;
    end else if (adv) begin
      tag7_r       <= tag6;
      byp_valid_r  <= tag7_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod7_r    <= prod6;
      byp_addr_r <= tag7_r.index[AW-1:0];
      byp_data_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && tag7_r.valid && tag7_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tag7_r.valid && tag7_r.last) begin
      out_idx_r <= tag7_r.index;
      out_val_r <= acc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_val_r, out_idx_r};

endmodule

// File: rtl/mvacc_chk.sv
module mvacc_chk #(
  parameter int MODULUS  = 8380417,
  parameter int N_COEFFS = 256
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [mvacc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // no result survives reset
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // emitted coefficient is fully reduced
  a_val_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[mvacc_pkg::OUT_VAL_LSB +: mvacc_pkg::VAL_W] < MODULUS))
    else $error("result not reduced");

  // only in-range positions produce results; pad bit stays clear
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[mvacc_pkg::OUT_IDX_LSB +: mvacc_pkg::IDX_W] < N_COEFFS)
                    && (out_tdata[mvacc_pkg::OUT_TDATA_W-1] == 1'b0)))
    else $error("result position out of range");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // input only backs off behind a held result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled with the result side free");

endmodule

bind modq_matrix_vector_accumulate mvacc_chk #(
  .MODULUS  (MODULUS),
  .N_COEFFS (N_COEFFS)
) u_mvacc_chk (.*);
